[rtl/ntc_thermistor_to_celsius_core_defines.svh]
`ifndef NTC_THERMISTOR_TO_CELSIUS_CORE_DEFINES_SVH
`define NTC_THERMISTOR_TO_CELSIUS_CORE_DEFINES_SVH

// same-cycle implication
`define NTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ntc assertion failed");

// next-cycle implication
`define NTC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ntc assertion failed");

`endif

[rtl/ntc_pkg.sv]
package ntc_pkg;
	localparam int unsigned CHANNELS_DEF = 16;
	localparam int unsigned BETA_W = 14;
	localparam int unsigned CODE_W = 16;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned LN_W = 20;
	localparam int unsigned QUO_BITS = 27;

	localparam logic [CFG_IDX_W-1:0] REG_BETA = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd1;

	localparam logic [BETA_W-1:0] BETA_RESET = 14'd3435;
	localparam logic [CODE_W-1:0] FS_RESET = 16'd30000;

	localparam logic [15:0] LN2_Q = 16'd45426;
	localparam logic [14:0] T0_HUND = 15'd29815;
	localparam logic signed [28:0] KELVIN_OFF = 29'sd17901158;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic signed [12:0] TEMP_MIN = -13'sd128;
	localparam logic signed [12:0] TEMP_MAX = 13'sd1023;

	// ln(1 + i/16) in Q0.16
	function automatic logic [15:0] ln_tab(input logic [4:0] i);
		logic [15:0] r;
		case (i)
			5'd0: r = 16'd0;
			5'd1: r = 16'd3973;
			5'd2: r = 16'd7719;
			5'd3: r = 16'd11262;
			5'd4: r = 16'd14624;
			5'd5: r = 16'd17821;
			5'd6: r = 16'd20870;
			5'd7: r = 16'd23783;
			5'd8: r = 16'd26573;
			5'd9: r = 16'd29248;
			5'd10: r = 16'd31818;
			5'd11: r = 16'd34298;
			5'd12: r = 16'd36675;
			5'd13: r = 16'd38975;
			5'd14: r = 16'd41196;
			5'd15: r = 16'd43352;
			5'd16: r = 16'd45426;
			default: r = 16'd0;
		endcase
		return r;
	endfunction
endpackage

[rtl/ntc_thermistor_to_celsius_core.sv]
// An item passes stages 1-5, the divider load, the divider and an output register.
// Throughput: one item per cycle, the 27-stage restoring divider setting the depth;
// the whole pipeline holds while a result waits on out_ready.
// Reset clears all valid bits and loads beta_factor 3435 and full_scale_code 30000.
`include "ntc_thermistor_to_celsius_core_defines.svh"

module ntc_thermistor_to_celsius_core #(
	parameter int unsigned CHANNELS_PER_MODULE = ntc_pkg::CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ntc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ntc_pkg::CFG_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [3:0] device_index,
	input logic [3:0] channel_index,
	input logic [ntc_pkg::CODE_W-1:0] adc_code,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] slot_index,
	output logic signed [10:0] temperature_c,
	output logic [1:0] status
);
	import ntc_pkg::*;

	localparam int unsigned QB = QUO_BITS;

	logic [BETA_W-1:0] beta_q;
	logic [CODE_W-1:0] fs_q;
	logic en;

	logic [7:0] slot_sum;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [CODE_W-1:0] code_s1, diff_s1;
	logic [7:0] slot_s1, slot_s2, slot_s3, slot_s4, slot_s5;
	logic [1:0] st_s1, st_s2, st_s3, st_s4, st_s5;

	logic [LN_W-1:0] lna_s3, lnb_s3;
	logic [28:0] bnum_s3, bnum_s4, bnum_s5;
	logic [20:0] b100_s3, b100_s4;
	logic signed [20:0] lq;
	logic signed [35:0] lqm_s4;
	logic signed [38:0] den_s5;

	logic div_v_s [0:QB];
	logic div_hot_s [0:QB];
	logic [7:0] div_slot_s [0:QB];
	logic [1:0] div_st_s [0:QB];
	logic [60:0] div_rem_s [0:QB];
	logic [37:0] div_den_s [0:QB];
	logic [QB-1:0] div_quo_s [0:QB];

	logic signed [28:0] cq;
	logic [28:0] mag;
	logic signed [12:0] whole;
	logic signed [12:0] clamped;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= BETA_RESET;
			fs_q <= FS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BETA: beta_q <= cfg_wdata[BETA_W-1:0];
				REG_FULL_SCALE: fs_q <= cfg_wdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: classify
	assign slot_sum = 8'(device_index) * 8'(CHANNELS_PER_MODULE) + 8'(channel_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s1 <= adc_code;
			diff_s1 <= fs_q - adc_code;
			slot_s1 <= slot_sum;
			if (adc_code == '0) begin
				st_s1 <= ST_ZERO;
			end else if (adc_code >= fs_q) begin
				st_s1 <= ST_FULL;
			end else begin
				st_s1 <= ST_OK;
			end
			slot_s2 <= slot_s1;
			st_s2 <= st_s1;
			slot_s3 <= slot_s2;
			st_s3 <= st_s2;
			slot_s4 <= slot_s3;
			st_s4 <= st_s3;
			slot_s5 <= slot_s4;
			st_s5 <= st_s4;
		end
	end

	// stages 2-3: logarithms
	ntc_ln u_ln_code (
		.clk(clk),
		.en(en),
		.x(code_s1),
		.ln(lna_s3)
	);

	ntc_ln u_ln_diff (
		.clk(clk),
		.en(en),
		.x(diff_s1),
		.ln(lnb_s3)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			bnum_s3 <= 29'(beta_q) * 29'(T0_HUND);
			b100_s3 <= 21'(beta_q) * 21'd100;
		end
	end

	// stage 4: scaled log ratio
	assign lq = signed'(21'(lna_s3)) - signed'(21'(lnb_s3));

	always_ff @(posedge clk) begin
		if (en) begin
			lqm_s4 <= 36'(lq) * signed'(36'(T0_HUND));
			bnum_s4 <= bnum_s3;
			b100_s4 <= b100_s3;
		end
	end

	// stage 5: denominator
	always_ff @(posedge clk) begin
		if (en) begin
			den_s5 <= signed'(39'({b100_s4, 16'b0})) + 39'(lqm_s4);
			bnum_s5 <= bnum_s4;
		end
	end

	// stage 6: overflow check and divider load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s[0] <= 1'b0;
		end else if (en) begin
			div_v_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_hot_s[0] <= den_s5[38] || (den_s5 == '0) ||
				(65'({bnum_s5, 32'b0}) >= 65'({den_s5[37:0], 27'b0}));
			div_rem_s[0] <= {bnum_s5, 32'b0};
			div_den_s[0] <= den_s5[37:0];
			div_quo_s[0] <= '0;
			div_slot_s[0] <= slot_s5;
			div_st_s[0] <= st_s5;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar j = 1; j <= QB; j++) begin : g_div
		logic [64:0] trial;

		assign trial = 65'(div_rem_s[j-1]) - (65'(div_den_s[j-1]) << (QB - j));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j] <= 1'b0;
			end else if (en) begin
				div_v_s[j] <= div_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_den_s[j] <= div_den_s[j-1];
				div_hot_s[j] <= div_hot_s[j-1];
				div_slot_s[j] <= div_slot_s[j-1];
				div_st_s[j] <= div_st_s[j-1];
				if (!trial[64]) begin
					div_rem_s[j] <= trial[60:0];
					div_quo_s[j] <= div_quo_s[j-1] | (QB'(1) << (QB - j));
				end else begin
					div_rem_s[j] <= div_rem_s[j-1];
					div_quo_s[j] <= div_quo_s[j-1];
				end
			end
		end
	end

	// Kelvin to Celsius, truncate toward zero, saturate
	assign cq = signed'(29'(div_quo_s[QB])) - KELVIN_OFF;
	assign mag = 29'(-cq);
	assign whole = cq[28] ? -signed'(13'(mag >> 16)) : signed'(13'(cq >>> 16));

	always_comb begin
		if (div_hot_s[QB] || whole > TEMP_MAX) begin
			clamped = TEMP_MAX;
		end else if (whole < TEMP_MIN) begin
			clamped = TEMP_MIN;
		end else begin
			clamped = whole;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= div_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_index <= div_slot_s[QB];
			status <= div_st_s[QB];
			temperature_c <= (div_st_s[QB] == ST_OK) ? 11'(clamped) : '0;
		end
	end

	`NTC_ASSERT_IMP(a_fault_zero, out_valid && status != ST_OK, temperature_c == '0)
	`NTC_ASSERT_IMP(a_status_code, out_valid, status == ST_OK || status == ST_ZERO || status == ST_FULL)
	`NTC_ASSERT_IMP(a_temp_floor, out_valid, temperature_c >= 11'sd0 - 11'sd128)
	`NTC_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
	`NTC_ASSERT_NXT(a_hold_on_stall, out_valid && !out_ready, out_valid && $stable(status))
endmodule

[rtl/ntc_ln.sv]
module ntc_ln (
	input logic clk,
	input logic en,
	input logic [ntc_pkg::CODE_W-1:0] x,
	output logic [ntc_pkg::LN_W-1:0] ln
);
	import ntc_pkg::*;

	logic [3:0] e;
	logic [31:0] sh;
	logic [15:0] f;
	logic [4:0] idx;
	logic [3:0] e_s2;
	logic [15:0] lo_s2;
	logic [11:0] dif_s2;
	logic [11:0] rem_s2;
	logic [23:0] prod;

	// leading one position
	always_comb begin
		e = '0;
		for (int i = 1; i < CODE_W; i++) begin
			if (x[i]) begin
				e = 4'(i);
			end
		end
	end

	assign sh = 32'(x) << (5'd16 - 5'(e));
	assign f = sh[15:0];
	assign idx = {1'b0, f[15:12]};

	always_ff @(posedge clk) begin
		if (en) begin
			e_s2 <= e;
			lo_s2 <= ln_tab(idx);
			dif_s2 <= 12'(ln_tab(idx + 5'd1) - ln_tab(idx));
			rem_s2 <= f[11:0];
		end
	end

	assign prod = 24'(dif_s2) * 24'(rem_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			ln <= LN_W'(20'(e_s2) * 20'(LN2_Q)) + LN_W'(lo_s2) + LN_W'(prod[23:12]);
		end
	end
endmodule

[bench/tb_ntc_thermistor_to_celsius_core.sv]
module tb_ntc_thermistor_to_celsius_core;
	timeunit 1ns;
	timeprecision 1ps;
	import ntc_pkg::*;

	typedef struct packed {
		logic [3:0] dev;
		logic [3:0] chan;
		logic [15:0] code;
	} sample_t;

	typedef struct packed {
		logic [7:0] slot;
		logic signed [10:0] temp;
		logic [1:0] stat;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] device_index = '0;
	logic [3:0] channel_index = '0;
	logic [15:0] adc_code = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] slot_index;
	logic signed [10:0] temperature_c;
	logic [1:0] status;

	ntc_thermistor_to_celsius_core u_top (.*);

	sample_t pending_samples[$];
	reading_t expected_readings[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic in_taken = 1'b0;
	logic [13:0] beta_reg = 14'd3435;
	logic [15:0] fs_reg = 16'd30000;

	const int signed LN_STEPS[17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
		26573, 29248, 31818, 34298, 36675, 38975, 41196, 43352, 45426};

	initial forever #1 clk = ~clk;

	function automatic longint ln_fixed(input logic [15:0] x);
		int e;
		longint m, f, lo, hi;
		e = 0;
		if (x == 0)
			return 0;
		while (e < 15 && (x >> (e + 1)) != 0)
			e++;
		m = (longint'(x) << 16) >> e;
		f = m - 65536;
		lo = LN_STEPS[(f >> 12) & 15];
		hi = LN_STEPS[((f >> 12) & 15) + 1];
		return e * 45426 + lo + (((hi - lo) * (f & 12'hFFF)) >> 12);
	endfunction

	function automatic reading_t convert_sample(input sample_t s);
		reading_t r;
		longint lq, num, den, tq, cq, whole;
		r.slot = 8'((s.dev * 16) + s.chan);
		r.temp = '0;
		if (s.code == 0)
			r.stat = ST_ZERO;
		else if (s.code >= fs_reg)
			r.stat = ST_FULL;
		else begin
			r.stat = ST_OK;
			lq = ln_fixed(s.code) - ln_fixed(16'(fs_reg - s.code));
			num = longint'(beta_reg) * 29815 * 65536 * 65536;
			den = longint'(beta_reg) * 100 * 65536 + lq * 29815;
			if (den <= 0)
				whole = 1023;
			else begin
				tq = num / den;
				cq = tq - 17901158;
				whole = (cq < 0) ? -((-cq) / 65536) : cq / 65536;
				if (whole < -128)
					whole = -128;
				if (whole > 1023)
					whole = 1023;
			end
			r.temp = 11'(whole);
		end
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					sample_t s;
					s = pending_samples.pop_front();
					in_valid <= 1'b1;
					device_index <= s.dev;
					channel_index <= s.chan;
					adc_code <= s.code;
				end else
					in_valid <= 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		in_taken = in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_readings.push_back(convert_sample({device_index, channel_index, adc_code}));
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected result slot %0d temp %0d status %0d", $time,
						slot_index, temperature_c, status);
					errors++;
				end else begin
					reading_t e;
					e = expected_readings.pop_front();
					if (e.slot !== slot_index || e.temp !== temperature_c || e.stat !== status) begin
						$display("%0t: expected slot %0d temp %0d status %0d, got %0d %0d %0d",
							$time, e.slot, e.temp, e.stat, slot_index, temperature_c, status);
						errors++;
					end
				end
			end
		end
	end

	task automatic drain();
		while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BETA)
			beta_reg = val[13:0];
		else
			fs_reg = val;
	endtask

	function automatic sample_t rand_sample();
		sample_t s;
		s.dev = 4'($urandom);
		s.chan = 4'($urandom);
		case ($urandom_range(9))
			0: s.code = 16'($urandom);
			1: s.code = 16'($urandom_range(3));
			2: s.code = fs_reg - 16'($urandom_range(2)) + 16'($urandom_range(2));
			default: s.code = (fs_reg > 1) ? 16'($urandom_range(fs_reg - 1, 1)) : 16'd1;
		endcase
		return s;
	endfunction

	initial begin
		logic [15:0] fs_list[5] = '{16'd30000, 16'd1, 16'd65535, 16'd4096, 16'd2};
		logic [15:0] beta_list[5] = '{16'd3435, 16'd10000, 16'd1000, 16'd16383, 16'd0};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners under reset settings
		pending_samples.push_back('{4'd0, 4'd0, 16'd0});
		pending_samples.push_back('{4'd15, 4'd15, 16'd65535});
		pending_samples.push_back('{4'd15, 4'd0, 16'd30000});
		pending_samples.push_back('{4'd0, 4'd15, 16'd29999});
		pending_samples.push_back('{4'd5, 4'd10, 16'd1});
		pending_samples.push_back('{4'd10, 4'd5, 16'd15000});
		pending_samples.push_back('{4'd3, 4'd12, 16'd2});
		pending_samples.push_back('{4'd12, 4'd3, 16'd32768});
		pending_samples.push_back('{4'd1, 4'd1, 16'd100});
		pending_samples.push_back('{4'd9, 4'd6, 16'd29000});
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_BETA, beta_list[ph]);
			write_reg(REG_FULL_SCALE, fs_list[ph]);
			for (int k = 0; k < 4; k++) begin
				send_idle_pct = (k == 1 || k == 3) ? ((k == 1) ? 84 : 36) : 0;
				recv_stall_pct = (k == 2) ? 84 : ((k == 3) ? 36 : 0);
				repeat (50) pending_samples.push_back(rand_sample());
				if (k == 1)
					drain();
			end
			drain();
		end

		if (errors == 0)
			$display("tb_ntc_thermistor_to_celsius_core passed");
		else
			$display("tb_ntc_thermistor_to_celsius_core failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb_ntc_thermistor_to_celsius_core failed");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/ntc_pkg.sv
rtl/ntc_ln.sv
rtl/ntc_thermistor_to_celsius_core.sv
bench/tb_ntc_thermistor_to_celsius_core.sv
